// ===== src/asa_pkg.sv =====
package asa_pkg;

	// Storage and accumulation sizing
	localparam int MAX_SLOTS    = 8;
	localparam int LOG2_SAMPLES = 4;

	// Fixed field widths
	localparam int SAMPLE_W = 10;
	localparam int SLOT_W   = 3;
	localparam int MUX_W    = 4;
	localparam int CNT_CFG_W = 4;
	localparam int LIST_W   = 32;
	localparam int LIST_SLOTS = 8;

	// Slots that can actually hold an average: the list holds eight entries
	localparam int AVG_DEPTH = (MAX_SLOTS < LIST_SLOTS) ? MAX_SLOTS : LIST_SLOTS;

	localparam int ACC_W = SAMPLE_W + LOG2_SAMPLES;
	localparam int CNT_W = LOG2_SAMPLES + 1;

	// Stream payload widths
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT = 1'b0,
		REG_CHANNEL_LIST  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_CONVERSION = 1'b0,
		KIND_READ       = 1'b1
	} item_kind_t;

endpackage

// ===== src/adc_scan_averager_core.sv =====
// ADC scan averager.
// Input stream (s_axis_*): one transfer per event. tuser carries the kind
// (conversion done or read request); tdata carries the 10-bit sample in
// bits 9:0 and the slot to read in bits 12:10.
// Output stream (m_axis_*): exactly one transfer per input transfer, in order.
// tdata carries the average in bits 9:0 (zero for conversion events) and the
// mux channel of the slot now being sampled in bits 13:10.
// Configuration: cfg_wen/cfg_index/cfg_data write channel_count (index 0)
// or channel_list (index 1); write only while no event is in flight.
// The result passes the input register, then the result register, before it
// is offered on the output. Throughput: one event per cycle while the output
// is not stalled; the accumulate/store/advance update is a single pass of
// logic between those two registers.
// Reset clears the slot pointer, sample count, accumulator, all stored
// averages, channel_count to 1 and channel_list to 0.
// When the receiver stalls, the result register holds its transfer; the input
// register still takes one more event, after which s_axis_tready drops until
// the result is taken.
module adc_scan_averager_core
	import asa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample[9:0], slot[12:10], zero fill
	input  logic                   s_axis_tuser,  // kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // average[9:0], mux_channel[13:10], zero fill
	input  logic                   cfg_wen,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers
	logic [CNT_CFG_W-1:0] channel_count_q;
	logic [LIST_W-1:0]    channel_list_q;

	// Scan state
	logic [ACC_W-1:0]    acc_q;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   cur_slot_q;
	logic [SAMPLE_W-1:0] avg_q [AVG_DEPTH];

	// Input register
	logic                valid_s1;
	item_kind_t          kind_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SLOT_W-1:0]   slot_s1;

	// Result register
	logic                   out_valid_q;
	logic [SAMPLE_W-1:0]    out_avg_q;
	logic [MUX_W-1:0]       out_mux_q;

	logic                 advance;
	logic                 do_conv;
	logic                 window_full;
	logic                 store_avg;
	logic [CNT_CFG_W-1:0] slot_limit;
	logic [CNT_CFG_W-1:0] slot_plus1;
	logic [SLOT_W-1:0]    slot_next;
	logic [SAMPLE_W-1:0]  read_avg;
	logic [SAMPLE_W-1:0]  new_avg;
	logic [MUX_W-1:0]     mux_next;

	// The stage moves forward whenever the result register is free or drained
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	assign do_conv     = valid_s1 && advance && (kind_s1 == KIND_CONVERSION);
	assign window_full = count_q[LOG2_SAMPLES];
	assign store_avg   = do_conv && window_full;
	assign new_avg     = acc_q[ACC_W-1:LOG2_SAMPLES];

	// Effective slot count: zero acts as one, then saturate to storage
	always_comb begin
		slot_limit = channel_count_q;
		if (slot_limit == '0) begin
			slot_limit = CNT_CFG_W'(1);
		end
		if (slot_limit > CNT_CFG_W'(AVG_DEPTH)) begin
			slot_limit = CNT_CFG_W'(AVG_DEPTH);
		end
	end

	assign slot_plus1 = {1'b0, cur_slot_q} + CNT_CFG_W'(1);

	// Wrap after the last slot; also wraps when the count was lowered mid-scan
	always_comb begin
		slot_next = cur_slot_q;
		if (store_avg) begin
			if (slot_plus1 >= slot_limit) begin
				slot_next = '0;
			end else begin
				slot_next = slot_plus1[SLOT_W-1:0];
			end
		end
	end

	// Read port of the average store; a slot without storage reads zero
	always_comb begin
		read_avg = '0;
		for (int i = 0; i < AVG_DEPTH; i++) begin
			if (slot_s1 == SLOT_W'(i)) begin
				read_avg = avg_q[i];
			end
		end
	end

	assign mux_next = channel_list_q[slot_next*MUX_W +: MUX_W];

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CNT_CFG_W'(1);
			channel_list_q  <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CNT_CFG_W-1:0];
				REG_CHANNEL_LIST:  channel_list_q  <= cfg_data[LIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1   <= item_kind_t'(s_axis_tuser);
			sample_s1 <= s_axis_tdata[SAMPLE_W-1:0];
			slot_s1   <= s_axis_tdata[SAMPLE_W +: SLOT_W];
		end
	end

	// Accumulate, or close the window: store, clear and step to the next slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			count_q    <= '0;
			cur_slot_q <= '0;
			for (int i = 0; i < AVG_DEPTH; i++) begin
				avg_q[i] <= '0;
			end
		end else if (do_conv) begin
			if (!window_full) begin
				acc_q   <= acc_q + ACC_W'(sample_s1);
				count_q <= count_q + CNT_W'(1);
			end else begin
				for (int i = 0; i < AVG_DEPTH; i++) begin
					if (cur_slot_q == SLOT_W'(i)) begin
						avg_q[i] <= new_avg;
					end
				end
				acc_q      <= '0;
				count_q    <= '0;
				cur_slot_q <= slot_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_avg_q <= (kind_s1 == KIND_READ) ? read_avg : '0;
			out_mux_q <= mux_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-SAMPLE_W-MUX_W){1'b0}}, out_mux_q, out_avg_q};

endmodule

// ===== src/asa_checker.sv =====
module asa_checker
	import asa_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   s_axis_tuser,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic s_xfer;

	assign s_xfer = s_axis_tvalid && s_axis_tready;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed or dropped");

	// Input backpressure only comes from a full, stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

	// An accepted event is on the output if the output is ready after it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("result missing after accepted transfer");

	// Conversion events report a zero average
	a_conv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer && (s_axis_tuser == KIND_CONVERSION) ##1 m_axis_tready
		|=> m_axis_tdata[SAMPLE_W-1:0] == '0)
		else $error("nonzero average on conversion result");

endmodule

bind adc_scan_averager_core asa_checker u_asa_checker (.*);
